/* sv/mi3_pkg.sv */
package mi3_pkg;

  // Element and quotient width (signed two's complement)
  localparam int DATA_W = 32;
  // Number of matrix elements
  localparam int NELEM = 9;
  // Cofactor width (wraps to 64 bits) and magnitude width
  localparam int COF_W = 64;
  localparam int MAG_W = 64;
  // Signed determinant width and its magnitude width
  localparam int DET_W = 98;
  localparam int DEN_W = 97;
  // Default fraction bits
  localparam int FRAC_BITS_DEF = 16;
  // Depth of the queue between front and back (power of two)
  localparam int QDEPTH = 4;

  // One classified matrix handed from front to back, in output order
  typedef struct packed {
    logic [NELEM-1:0]            neg;
    logic [NELEM-1:0][MAG_W-1:0] mag;
    logic [DEN_W-1:0]            den;
    logic                        singular;
  } job_t;

endpackage

/* sv/mi3_front.sv */
module mi3_front #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [mi3_pkg::NELEM-1:0][mi3_pkg::DATA_W-1:0] in_data,
  output logic                                          job_valid,
  input  logic                                          job_ready,
  output mi3_pkg::job_t                                 job
);
  import mi3_pkg::*;

  // Operand indices: cof[i] = a[PA]*a[PB] - a[PC]*a[PD], model row-major order
  localparam int PA [NELEM] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int PB [NELEM] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int PC [NELEM] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int PD [NELEM] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

  logic                      en;
  logic [6:1]                v_r;
  logic signed [COF_W-1:0]   pa_r [NELEM];
  logic signed [COF_W-1:0]   pb_r [NELEM];
  logic signed [DATA_W-1:0]  row1_r [3];
  logic signed [DATA_W-1:0]  row2_r [3];
  logic signed [COF_W-1:0]   cof2_r [NELEM];
  logic signed [COF_W-1:0]   cof3_r [NELEM];
  logic signed [COF_W-1:0]   cof4_r [NELEM];
  logic signed [COF_W-1:0]   cof5_r [NELEM];
  logic signed [63:0]        hi_r [3];
  logic signed [65:0]        lo_r [3];
  logic signed [DET_W-1:0]   t_r [3];
  logic signed [DET_W-1:0]   det_r;
  job_t                      job_r;
  job_t                      job_nxt;
  logic signed [DET_W-1:0]   det_abs;
  logic                      det_neg;

  // Whole pipeline advances together unless the last stage is held
  assign en        = !v_r[6] || job_ready;
  assign in_ready  = en;
  assign job_valid = v_r[6];
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:1], in_valid};
    end
  end

  // Stage 1: the eighteen 2x2 products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NELEM; i++) begin
        pa_r[i] <= $signed(in_data[PA[i]]) * $signed(in_data[PB[i]]);
        pb_r[i] <= $signed(in_data[PC[i]]) * $signed(in_data[PD[i]]);
      end
      for (int k = 0; k < 3; k++) begin
        row1_r[k] <= $signed(in_data[k]);
      end
    end
  end

  // Stage 2: cofactors, wrapped to 64 bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NELEM; i++) begin
        cof2_r[i] <= pa_r[i] - pb_r[i];
      end
      row2_r <= row1_r;
    end
  end

  // Stage 3: a0k times C0k, with C0k split into two 32-bit halves for two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        hi_r[k] <= row2_r[k] * $signed(cof2_r[k][63:32]);
        lo_r[k] <= $signed({row2_r[k][DATA_W-1], row2_r[k]}) *
                   $signed({1'b0, cof2_r[k][31:0]});
      end
      cof3_r <= cof2_r;
    end
  end

  // Stage 4: recombine the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t_r[k] <= ({{(DET_W-64){hi_r[k][63]}}, hi_r[k]} << 32) +
                  {{(DET_W-66){lo_r[k][65]}}, lo_r[k]};
      end
      cof4_r <= cof3_r;
    end
  end

  // Stage 5: determinant
  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= t_r[0] + t_r[1] + t_r[2];
      cof5_r <= cof4_r;
    end
  end

  // Stage 6: signs, magnitudes, singular substitution, transpose
  always_comb begin
    det_abs = det_r[DET_W-1] ? -det_r : det_r;
    job_nxt.singular = (det_r == '0);
    det_neg = det_r[DET_W-1];
    if (job_nxt.singular) begin
      job_nxt.den = DEN_W'(1) << (3 * FRAC_BITS);
    end else begin
      job_nxt.den = det_abs[DEN_W-1:0];
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        job_nxt.mag[r*3+k] = cof5_r[k*3+r][COF_W-1] ? MAG_W'(-cof5_r[k*3+r])
                                                    : MAG_W'(cof5_r[k*3+r]);
        job_nxt.neg[r*3+k] = cof5_r[k*3+r][COF_W-1] ^ det_neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job_r <= job_nxt;
    end
  end

endmodule

/* sv/mi3_fifo.sv */
module mi3_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  mi3_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mi3_pkg::job_t pop_data
);
  import mi3_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QDEPTH)) else $error("queue fill level out of range");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("fill level missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> wr_r == rd_r) else $error("pointers disagree on empty queue");

endmodule

/* sv/mi3_back.sv */
module mi3_back #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          job_valid,
  output logic                                          job_ready,
  input  mi3_pkg::job_t                                 job,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [mi3_pkg::NELEM-1:0][mi3_pkg::DATA_W-1:0] out_data,
  output logic [1:0]                                    out_flags
);
  import mi3_pkg::*;

  localparam int NUM_W = MAG_W + 2 * FRAC_BITS;
  localparam int SH_W  = DEN_W + DATA_W;
  localparam int W     = (NUM_W > SH_W ? NUM_W : SH_W) + 1;
  localparam int NS    = DATA_W;

  logic                en;
  logic [NS:0]         vld_r;
  logic [W-1:0]        rem_r [NS+1][NELEM];
  logic [DATA_W-1:0]   q_r   [NS+1][NELEM];
  logic [W-1:0]        den_r [NS+1];
  logic [NELEM-1:0]    neg_r [NS+1];
  logic [NELEM-1:0]    ovf_r [NS+1];
  logic                sing_r [NS+1];
  logic [W-1:0]        den_in;
  logic                out_valid_r;
  logic [NELEM-1:0][DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]          out_flags_r;
  logic                sat_nxt;

  assign en        = !out_valid_r || out_ready;
  assign job_ready = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_flags = out_flags_r;
  assign den_in    = {{(W-DEN_W){1'b0}}, job.den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NS-1:0], job_valid};
      out_valid_r <= vld_r[NS];
    end
  end

  // Load: scaled numerators and the quotient-too-large test
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NELEM; i++) begin
        rem_r[0][i]    <= {{(W-MAG_W){1'b0}}, job.mag[i]} << (2 * FRAC_BITS);
        q_r[0][i]      <= '0;
        ovf_r[0][i]    <= (({{(W-MAG_W){1'b0}}, job.mag[i]} << (2 * FRAC_BITS)) >=
                           (den_in << DATA_W));
      end
      den_r[0]  <= den_in;
      neg_r[0]  <= job.neg;
      sing_r[0] <= job.singular;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 1; s <= NS; s++) begin : g_div
    localparam int B = NS - s;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < NELEM; i++) begin
          if (rem_r[s-1][i] >= (den_r[s-1] << B)) begin
            rem_r[s][i] <= rem_r[s-1][i] - (den_r[s-1] << B);
            q_r[s][i]   <= q_r[s-1][i] | (DATA_W'(1) << B);
          end else begin
            rem_r[s][i] <= rem_r[s-1][i];
            q_r[s][i]   <= q_r[s-1][i];
          end
        end
        den_r[s]  <= den_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        sing_r[s] <= sing_r[s-1];
      end
    end
  end

  // Sign and saturation
  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < NELEM; i++) begin
      if (neg_r[NS][i]) begin
        if (ovf_r[NS][i] || q_r[NS][i] > 32'h8000_0000) begin
          out_data_nxt[i] = 32'h8000_0000;
          sat_nxt = 1'b1;
        end else begin
          out_data_nxt[i] = -q_r[NS][i];
        end
      end else begin
        if (ovf_r[NS][i] || q_r[NS][i][DATA_W-1]) begin
          out_data_nxt[i] = 32'h7FFF_FFFF;
          sat_nxt = 1'b1;
        end else begin
          out_data_nxt[i] = q_r[NS][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r  <= out_data_nxt;
      out_flags_r <= {sat_nxt, sing_r[NS]};
    end
  end

endmodule

/* sv/matrix_inverse_3x3.sv */
// 3x3 inverse by the adjugate in signed fixed point (FRAC_BITS fraction bits,
// Q16.16 by default). Each transfer on the input carries one matrix and yields
// one transfer on the output with the true inverse, each element truncated
// toward zero and clipped to 32 bits (saturated flag), and a singular flag when
// the determinant is zero, in which case the adjugate itself is returned.
// One matrix is taken per cycle while nothing downstream holds it back; a matrix
// passes the cofactor and determinant pipeline, the four-entry queue, the
// bit-per-stage divider bank and one output register.
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22, 32b each
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // inv00,inv01,...,inv22, 32b each
  output logic [1:0]   out_tuser   // singular, saturated
);
  import mi3_pkg::*;

  job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;
  logic [NELEM-1:0][DATA_W-1:0] out_data;

  mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  mi3_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_job)
  );

  mi3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data),
    .out_flags (out_tuser)
  );

  assign out_tdata = out_data;

endmodule

/* tb/sv/mi3_checker.sv */
module mi3_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [287:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [287:0] out_tdata,
  input  logic [1:0]   out_tuser,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = mi3_pkg::FRAC_BITS_DEF;

  typedef struct {
    logic [287:0] inv;
    logic         singular;
    logic         saturated;
  } inverse_t;

  inverse_t inverse_q[$];

  // one quotient: (cof << 2F) / den, truncated toward zero, clipped to 32 bits
  function automatic logic [31:0] clip_div(input logic signed [63:0] cof,
                                           input logic [127:0] den, input bit den_neg,
                                           inout bit sat);
    logic [127:0] num;
    logic [127:0] mag;
    bit neg;
    neg = (cof < 0) != den_neg;
    mag = (cof < 0) ? 128'(-cof) : 128'(cof);
    num = (mag << (2 * FB)) / den;
    if (neg) begin
      if (num > 128'h8000_0000) begin
        sat = 1;
        return 32'h8000_0000;
      end
      return 32'(-num);
    end
    if (num > 128'h7FFF_FFFF) begin
      sat = 1;
      return 32'h7FFF_FFFF;
    end
    return num[31:0];
  endfunction

  function automatic inverse_t invert_matrix(input logic [287:0] d);
    logic signed [63:0] a[3][3];
    logic signed [63:0] c[3][3];
    logic signed [127:0] det;
    logic [127:0] den;
    bit den_neg;
    bit sat;
    inverse_t r;
    sat = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a[i][j] = 64'(signed'(d[(i*3+j)*32 +: 32]));
    // cofactors wrap at 64 bits
    c[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
    c[0][1] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
    c[0][2] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
    c[1][0] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
    c[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
    c[1][2] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
    c[2][0] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
    c[2][1] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
    c[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
    det = 128'(a[0][0]) * 128'(c[0][0]) + 128'(a[0][1]) * 128'(c[0][1])
        + 128'(a[0][2]) * 128'(c[0][2]);
    den_neg = det < 0;
    den = den_neg ? 128'(-det) : 128'(det);
    r.singular = (det == 0);
    if (r.singular) begin
      den_neg = 0;
      den = 128'd1 << (3 * FB);
    end
    // transpose of the cofactors
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r.inv[(i*3+j)*32 +: 32] = clip_div(c[j][i], den, den_neg, sat);
    r.saturated = sat;
    return r;
  endfunction

  assign pending = inverse_q.size();

  always @(posedge clk) begin
    inverse_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      // predict on each input transfer
      if (in_tvalid && in_tready)
        inverse_q.push_back(invert_matrix(in_tdata));
      // compare on each output transfer
      if (out_tvalid && out_tready) begin
        if (inverse_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transfer %h", out_tdata);
        end else begin
          want = inverse_q.pop_front();
          if (want.inv !== out_tdata || want.singular !== out_tuser[0]
              || want.saturated !== out_tuser[1]) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp inv=%h sing=%b sat=%b got inv=%h sing=%b sat=%b",
                       want.inv, want.singular, want.saturated,
                       out_tdata, out_tuser[0], out_tuser[1]);
          end
        end
      end
    end
  end
endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 450;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ONE = 32'h0001_0000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [287:0] out_tdata;
  logic [1:0]   out_tuser;
  int           fail_count;
  int           pending;
  bit           calm;
  logic [287:0] mats[$];

  matrix_inverse_3x3 DUT (.*);

  mi3_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // element with a mix of typical and extreme values
  function automatic logic [31:0] pick_elem();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
      4, 5: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      6: return $urandom_range(0, 3) - 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [287:0] pack9(input logic [31:0] e[9]);
    logic [287:0] d;
    for (int i = 0; i < 9; i++) d[i*32 +: 32] = e[i];
    return d;
  endfunction

  // result-side stall bursts, none when calm
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 6);
    end
  end

  // watchdog on cycles without any transfer
  int quiet;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("matrix_inverse_3x3 regression: fail");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || calm || stall_left == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
    end
  end

  initial begin
    logic [31:0] e[9];
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    calm = 0;
    // directed: identity, scaled, zero, singular, extremes, tiny determinant
    e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};  mats.push_back(pack9(e));
    e = '{2*ONE, 0, 0, 0, -4*ONE, 0, 0, 0, ONE/2}; mats.push_back(pack9(e));
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};  mats.push_back(pack9(e));
    e = '{ONE, 2*ONE, 3*ONE, 2*ONE, 4*ONE, 6*ONE, 0, ONE, 5*ONE}; mats.push_back(pack9(e));
    e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};  mats.push_back(pack9(e));
    e = '{-1, 0, 0, 0, 1, 0, 0, 0, -1}; mats.push_back(pack9(e));
    for (int k = 0; k < 9; k++) e[k] = 32'h8000_0000;
    mats.push_back(pack9(e));
    for (int k = 0; k < 9; k++) e[k] = 32'h7FFF_FFFF;
    mats.push_back(pack9(e));
    e = '{32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000};
    mats.push_back(pack9(e));
    e = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, ONE};
    mats.push_back(pack9(e));
    e = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};  mats.push_back(pack9(e));
    e = '{32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF};
    mats.push_back(pack9(e));
    e = '{3*ONE, ONE, 0, ONE, 2*ONE, ONE, 0, ONE, 3*ONE}; mats.push_back(pack9(e));
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      for (int m = 0; m < 9; m++) e[m] = pick_elem();
      mats.push_back(pack9(e));
    end
    repeat (12) @(posedge clk);
    rst_n <= 1;
    while (mats.size() > 0) begin
      if (mats.size() < 60) calm <= 1;
      // input-side idle burst, valid dropped for its length
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      in_tvalid <= 1;
      in_tdata <= mats.pop_front();
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("matrix_inverse_3x3 regression: pass");
    end else begin
      $display("matrix_inverse_3x3 regression: fail");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/mi3_pkg.sv
sv/mi3_front.sv
sv/mi3_fifo.sv
sv/mi3_back.sv
sv/matrix_inverse_3x3.sv
tb/sv/mi3_checker.sv
tb/sv/tb.sv
